>>> design/swg_pkg.sv
// Shared types, codes and fixed-point helpers of the separable window grid unit.
// No dependencies; every other design file of the block but swg_ram, and the bench, import this package.
package swg_pkg;

	localparam logic [2:0] FN_LOAD   = 3'd0;
	localparam logic [2:0] FN_WRITE  = 3'd1;
	localparam logic [2:0] FN_READ   = 3'd2;
	localparam logic [2:0] FN_SPREAD = 3'd3;
	localparam logic [2:0] FN_GATHER = 3'd4;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
	localparam logic [1:0] REG_PLANE_ROWS = 2'd1;
	localparam logic [1:0] REG_TAPS_USED  = 2'd2;

	localparam int TAP_SPAN    = 8;
	localparam int CFG_W       = 17;
	localparam int ADDR_W      = 38;
	localparam int ACC_W       = 58;
	localparam int OUT_W       = 48;
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = 1;

	typedef struct packed {
		logic [2:0]         func;
		logic [1:0]         axis;
		logic [2:0]         tap;
		logic signed [15:0] weight;
		logic signed [15:0] dweight;
		logic [15:0]        grid_index;
		logic signed [31:0] value_re;
		logic signed [31:0] value_im;
	} swg_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] row_length;
		logic [CFG_W-1:0] plane_rows;
		logic [3:0]       taps_used;
	} swg_cfg_t;

	// round(p / 2^30), result fits 17 bits for 16-bit taps
	function automatic logic signed [16:0] rnd30(input logic signed [47:0] p);
		logic signed [47:0] t;
		t = p + 48'sd536870912;
		return t[46:30];
	endfunction

	// round(x / 2^15) of a value times a tensor weight
	function automatic logic signed [33:0] rnd15(input logic signed [48:0] x);
		logic signed [48:0] t;
		t = x + 49'sd16384;
		return t[48:15];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
		logic signed [31:0] r;
		if (x > 35'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -35'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

>>> design/swg_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module swg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> design/swg_front.sv
// Input side: accepts beats and drops the ones that cause no work at all.
// Depends on swg_pkg.
module swg_front import swg_pkg::*; #(
	parameter int MAX_TAPS = 8
) (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic [1:0]         axis,
	input  logic [2:0]         tap,
	input  logic signed [15:0] weight,
	input  logic signed [15:0] dweight,
	input  logic [15:0]        grid_index,
	input  logic signed [31:0] value_re,
	input  logic signed [31:0] value_im,
	input  logic               q_full,
	output logic               push,
	output swg_item_t          push_item
);
	logic keep;

	always_comb begin
		keep = (func <= FN_GATHER);
		if (func == FN_LOAD && (axis > AXIS_Z || int'(tap) >= MAX_TAPS)) begin
			keep = 1'b0;
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full && keep;

	assign push_item = '{func: func, axis: axis, tap: tap, weight: weight,
		dweight: dweight, grid_index: grid_index, value_re: value_re,
		value_im: value_im};
endmodule

>>> design/swg_queue.sv
// Short queue between the front and the back part.
// Depends on swg_pkg.
module swg_queue import swg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  swg_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output swg_item_t pop_item
);
	swg_item_t        slot_q [QUEUE_DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QP_W:0]    count_q;

	assign full      = (count_q == (QP_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> design/swg_back.sv
// Back part: sequencer over the cube, weight pipeline, grid memory and result register.
// Depends on swg_pkg and swg_ram.
module swg_back import swg_pkg::*; #(
	parameter int MAX_TAPS   = 8,
	parameter int GRID_CELLS = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swg_cfg_t              cfg,
	input  logic                  q_valid,
	input  swg_item_t             q_item,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [OUT_W-1:0] f_re,
	output logic signed [OUT_W-1:0] f_im,
	output logic signed [OUT_W-1:0] gx_re,
	output logic signed [OUT_W-1:0] gx_im,
	output logic signed [OUT_W-1:0] gy_re,
	output logic signed [OUT_W-1:0] gy_im,
	output logic signed [OUT_W-1:0] gz_re,
	output logic signed [OUT_W-1:0] gz_im,
	output logic                  range_error
);
	localparam int TW  = $clog2(MAX_TAPS);
	localparam int AW  = $clog2(GRID_CELLS);
	localparam int LIM = (MAX_TAPS < TAP_SPAN) ? MAX_TAPS : TAP_SPAN;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RUN    = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_RDWAIT = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] op_q;
	logic [15:0] base_q;
	logic signed [31:0] vre_q, vim_q;
	logic rd_in_q;
	logic err_q;

	logic signed [15:0] w_q [3][MAX_TAPS];
	logic signed [15:0] d_q [3][MAX_TAPS];

	logic [33:0] plane_q;
	logic [2:0]  a_q, b_q, c_q;
	logic [19:0] row_off_q;
	logic [36:0] plane_off_q;

	logic [3:0] t_eff;
	logic [2:0] t_last;
	logic [ADDR_W-1:0] addr0;
	logic in0;
	logic [TW-1:0] ia, ib, ic, tidx;

	// pipeline
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0] pxy_s1, dxy_s1, xdy_s1;
	logic signed [15:0] wz_s1, dz_s1;
	logic [ADDR_W-1:0] addr_s1, addr_s2;
	logic in_s1, in_s2, in_s3;
	logic [AW-1:0] ra_s3;
	logic signed [47:0] p_s2, gx_s2, gy_s2, gz_s2;
	logic signed [16:0] wt_s3, gxw_s3, gyw_s3, gzw_s3;
	logic signed [48:0] pre_s3, pim_s3;
	logic signed [48:0] m_s4 [8];

	logic signed [16:0] wt3, gxw3, gyw3, gzw3;
	logic signed [48:0] pre3, pim3;

	logic signed [ACC_W-1:0] acc_q [8];
	logic signed [OUT_W-1:0] out_q [8];
	logic err_out_q;

	// grid memory
	logic          ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [63:0]   ram_wd, ram_rd;

	logic wr_v_q;
	logic [AW-1:0] wr_a_q;
	logic [63:0]   wr_d_q;
	logic [63:0]   cell_rd;
	logic signed [31:0] cre, cim;
	logic signed [33:0] dre, dim;
	logic signed [31:0] nre, nim;
	logic spread_wr;
	logic item_in;
	logic drained;
	logic out_free;

	swg_ram #(.WIDTH(64), .DEPTH(GRID_CELLS)) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	always_comb begin
		t_eff  = (int'(cfg.taps_used) > LIM) ? 4'(LIM) : cfg.taps_used;
		t_last = 3'(t_eff - 4'd1);
		addr0  = ADDR_W'(base_q) + ADDR_W'(plane_off_q) + ADDR_W'(row_off_q) + ADDR_W'(c_q);
		in0    = addr0 < ADDR_W'(GRID_CELLS);
		ia     = TW'(a_q);
		ib     = TW'(b_q);
		ic     = TW'(c_q);
		tidx   = TW'(q_item.tap);
		item_in = (ADDR_W'(q_item.grid_index) < ADDR_W'(GRID_CELLS));
		pop    = (state_q == S_IDLE) && q_valid;
		drained = !v_s1 && !v_s2 && !v_s3 && !v_s4;
		out_free = !out_valid || !out_stall;
	end

	// S3: tensor weights and spread deltas
	always_comb begin
		wt3  = rnd30(p_s2);
		gxw3 = rnd30(gx_s2);
		gyw3 = rnd30(gy_s2);
		gzw3 = rnd30(gz_s2);
		pre3 = vre_q * wt3;
		pim3 = vim_q * wt3;
	end

	// S4: read data, with the write made in the previous cycle forwarded
	always_comb begin
		cell_rd = (wr_v_q && wr_a_q == ra_s3) ? wr_d_q : ram_rd;
		cre  = cell_rd[31:0];
		cim  = cell_rd[63:32];
		dre  = rnd15(pre_s3);
		dim  = rnd15(pim_s3);
		nre  = sat32({{3{cre[31]}}, cre} + {dre[33], dre});
		nim  = sat32({{3{cim[31]}}, cim} + {dim[33], dim});
		spread_wr = v_s3 && in_s3 && (op_q == FN_SPREAD);
	end

	always_comb begin
		if (spread_wr) begin
			ram_we = 1'b1;
			ram_wa = ra_s3;
			ram_wd = {nim, nre};
		end else begin
			ram_we = pop && q_item.func == FN_WRITE && item_in;
			ram_wa = AW'(q_item.grid_index);
			ram_wd = {q_item.value_im, q_item.value_re};
		end
		ram_ra = (state_q == S_IDLE) ? AW'(q_item.grid_index) : addr_s2[AW-1:0];
	end

	always_ff @(posedge clk) begin
		plane_q <= cfg.row_length * cfg.plane_rows;
		if (pop && q_item.func == FN_LOAD) begin
			w_q[q_item.axis][tidx] <= q_item.weight;
			d_q[q_item.axis][tidx] <= q_item.dweight;
		end
		// S1
		pxy_s1  <= w_q[0][ia] * w_q[1][ib];
		dxy_s1  <= d_q[0][ia] * w_q[1][ib];
		xdy_s1  <= w_q[0][ia] * d_q[1][ib];
		wz_s1   <= w_q[2][ic];
		dz_s1   <= d_q[2][ic];
		addr_s1 <= addr0;
		in_s1   <= in0;
		// S2
		p_s2    <= pxy_s1 * wz_s1;
		gx_s2   <= dxy_s1 * wz_s1;
		gy_s2   <= xdy_s1 * wz_s1;
		gz_s2   <= pxy_s1 * dz_s1;
		addr_s2 <= addr_s1;
		in_s2   <= in_s1;
		// S3
		wt_s3   <= wt3;
		gxw_s3  <= gxw3;
		gyw_s3  <= gyw3;
		gzw_s3  <= gzw3;
		pre_s3  <= pre3;
		pim_s3  <= pim3;
		ra_s3   <= addr_s2[AW-1:0];
		in_s3   <= in_s2;
		// S4: drop cells outside the store
		m_s4[0] <= in_s3 ? wt_s3 * cre : 49'sd0;
		m_s4[1] <= in_s3 ? wt_s3 * cim : 49'sd0;
		m_s4[2] <= in_s3 ? gxw_s3 * cre : 49'sd0;
		m_s4[3] <= in_s3 ? gxw_s3 * cim : 49'sd0;
		m_s4[4] <= in_s3 ? gyw_s3 * cre : 49'sd0;
		m_s4[5] <= in_s3 ? gyw_s3 * cim : 49'sd0;
		m_s4[6] <= in_s3 ? gzw_s3 * cre : 49'sd0;
		m_s4[7] <= in_s3 ? gzw_s3 * cim : 49'sd0;
		wr_a_q  <= ra_s3;
		wr_d_q  <= {nim, nre};
		if (pop) begin
			op_q    <= q_item.func;
			base_q  <= q_item.grid_index;
			vre_q   <= q_item.value_re;
			vim_q   <= q_item.value_im;
			rd_in_q <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			wr_v_q      <= 1'b0;
			out_valid   <= 1'b0;
			err_q       <= 1'b0;
			err_out_q   <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			row_off_q   <= '0;
			plane_off_q <= '0;
			for (int k = 0; k < 8; k++) begin
				acc_q[k] <= '0;
				out_q[k] <= '0;
			end
		end else begin
			v_s1   <= (state_q == S_RUN);
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3 && (op_q == FN_GATHER);
			wr_v_q <= spread_wr;
			// the result state loads a new beat itself when the old one leaves
			if (out_valid && !out_stall && state_q != S_RESULT) begin
				out_valid <= 1'b0;
			end
			if (v_s4) begin
				for (int k = 0; k < 8; k++) begin
					acc_q[k] <= acc_q[k] + {{(ACC_W-49){m_s4[k][48]}}, m_s4[k]};
				end
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						for (int k = 0; k < 8; k++) begin
							acc_q[k] <= '0;
						end
						a_q         <= '0;
						b_q         <= '0;
						c_q         <= '0;
						row_off_q   <= '0;
						plane_off_q <= '0;
						case (q_item.func)
							FN_WRITE: begin
								err_q   <= !item_in;
								state_q <= S_RESULT;
							end
							FN_READ: begin
								err_q   <= !item_in;
								state_q <= S_RDWAIT;
							end
							FN_SPREAD, FN_GATHER: begin
								err_q   <= 1'b0;
								state_q <= (t_eff == 4'd0) ? S_RESULT : S_RUN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RUN: begin
					if (!in0) begin
						err_q <= 1'b1;
					end
					if (c_q == t_last) begin
						c_q <= '0;
						if (b_q == t_last) begin
							b_q       <= '0;
							row_off_q <= '0;
							if (a_q == t_last) begin
								state_q <= S_DRAIN;
							end else begin
								a_q         <= a_q + 3'd1;
								plane_off_q <= plane_off_q + 37'(plane_q);
							end
						end else begin
							b_q       <= b_q + 3'd1;
							row_off_q <= row_off_q + 20'(cfg.row_length);
						end
					end else begin
						c_q <= c_q + 3'd1;
					end
				end
				S_DRAIN: begin
					if (drained) begin
						state_q <= S_RESULT;
					end
				end
				S_RDWAIT: begin
					if (rd_in_q) begin
						acc_q[0] <= ACC_W'($signed(ram_rd[31:0]));
						acc_q[1] <= ACC_W'($signed(ram_rd[63:32]));
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						for (int k = 0; k < 8; k++) begin
							if (op_q == FN_GATHER) begin
								out_q[k] <= OUT_W'((acc_q[k] + ACC_W'(16384)) >>> 15);
							end else begin
								out_q[k] <= acc_q[k][OUT_W-1:0];
							end
						end
						err_out_q <= err_q;
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign f_re        = out_q[0];
	assign f_im        = out_q[1];
	assign gx_re       = out_q[2];
	assign gx_im       = out_q[3];
	assign gy_re       = out_q[4];
	assign gy_im       = out_q[5];
	assign gz_re       = out_q[6];
	assign gz_im       = out_q[7];
	assign range_error = err_out_q;
endmodule

>>> design/separable_window_grid_spread_gather_unit.sv
// Top level of the separable window spread/gather unit: config registers and wiring.
// Depends on swg_pkg, swg_front, swg_queue, swg_back (and swg_ram below it).
//
// Usage:
//   Input channel (in_valid / in_stall) takes one command beat: load tap, write
//   cell, read cell, spread or gather. Output channel (out_valid / out_stall)
//   returns one result beat for write, read, spread and gather; tap loads and
//   unknown commands return nothing.
//   The config port (cfg_we, cfg_index, cfg_wdata) sets row_length, plane_rows and
//   taps_used; write it only while the unit is idle.
// Timing:
//   A spread or gather walks T*T*T cells (T = effective taps_used), one cell per
//   cycle through the single read port of the grid memory, then drains a four
//   stage weight pipeline. A write goes straight to the result state, a read
//   waits for the memory first. Work is done one beat at a time; the input
//   queue holds two beats so the sender keeps going while a result waits.
// Reset:
//   Clears the queue, the sequencer and the result register; config returns to
//   16, 16, 8. Grid cells and taps hold garbage until written.
// Stall:
//   A stalled result holds in the output register; the back part waits, the queue
//   fills, then in_stall rises.
module separable_window_grid_spread_gather_unit import swg_pkg::*; #(
	parameter int MAX_TAPS   = 8,
	parameter int GRID_CELLS = 65536
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              func,
	input  logic [1:0]              axis,
	input  logic [2:0]              tap,
	input  logic signed [15:0]      weight,
	input  logic signed [15:0]      dweight,
	input  logic [15:0]             grid_index,
	input  logic signed [31:0]      value_re,
	input  logic signed [31:0]      value_im,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] f_re,
	output logic signed [OUT_W-1:0] f_im,
	output logic signed [OUT_W-1:0] gx_re,
	output logic signed [OUT_W-1:0] gx_im,
	output logic signed [OUT_W-1:0] gy_re,
	output logic signed [OUT_W-1:0] gy_im,
	output logic signed [OUT_W-1:0] gz_re,
	output logic signed [OUT_W-1:0] gz_im,
	output logic                    range_error
);
	swg_cfg_t  cfg_q;
	logic      push, q_full, pop, q_valid;
	swg_item_t push_item, q_item;

	// config registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_length <= CFG_W'(16);
			cfg_q.plane_rows <= CFG_W'(16);
			cfg_q.taps_used  <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_LENGTH: cfg_q.row_length <= cfg_wdata;
				REG_PLANE_ROWS: cfg_q.plane_rows <= cfg_wdata;
				REG_TAPS_USED:  cfg_q.taps_used  <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// front: accept and filter beats
	swg_front #(.MAX_TAPS(MAX_TAPS)) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.axis       (axis),
		.tap        (tap),
		.weight     (weight),
		.dweight    (dweight),
		.grid_index (grid_index),
		.value_re   (value_re),
		.value_im   (value_im),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	// hold up to two beats between the sides
	swg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// back: walk the cube and produce results
	swg_back #(.MAX_TAPS(MAX_TAPS), .GRID_CELLS(GRID_CELLS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.f_re        (f_re),
		.f_im        (f_im),
		.gx_re       (gx_re),
		.gx_im       (gx_im),
		.gy_re       (gy_re),
		.gy_im       (gy_im),
		.gz_re       (gz_re),
		.gz_im       (gz_im),
		.range_error (range_error)
	);
endmodule

>>> verif/swg_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the separable window grid unit: snoops config, command and result beats.
// Keeps its own grid, taps and config; depends on swg_pkg.
module swg_checker import swg_pkg::*; #(
	parameter int MAX_TAPS   = 8,
	parameter int GRID_CELLS = 65536
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [2:0]              func,
	input  logic [1:0]              axis,
	input  logic [2:0]              tap,
	input  logic signed [15:0]      weight,
	input  logic signed [15:0]      dweight,
	input  logic [15:0]             grid_index,
	input  logic signed [31:0]      value_re,
	input  logic signed [31:0]      value_im,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [OUT_W-1:0] f_re,
	input  logic signed [OUT_W-1:0] f_im,
	input  logic signed [OUT_W-1:0] gx_re,
	input  logic signed [OUT_W-1:0] gx_im,
	input  logic signed [OUT_W-1:0] gy_re,
	input  logic signed [OUT_W-1:0] gy_im,
	input  logic signed [OUT_W-1:0] gz_re,
	input  logic signed [OUT_W-1:0] gz_im,
	input  logic                    range_error,
	output int                      mismatches,
	output int                      outstanding
);

	typedef struct packed {
		logic [7:0][OUT_W-1:0] sums;
		logic                  err;
	} cube_result_t;

	cube_result_t due_results[$];
	longint       row_len;
	longint       plane_cnt;
	int           taps_cfg;
	int           cell_re [GRID_CELLS];
	int           cell_im [GRID_CELLS];
	longint       win  [3][MAX_TAPS];
	longint       dwin [3][MAX_TAPS];
	string        sum_name [8] = '{"f_re", "f_im", "gx_re", "gx_im",
		"gy_re", "gy_im", "gz_re", "gz_im"};

	function automatic longint tensor(longint a, longint b, longint c);
		return (a * b * c + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint rnd15(longint x);
		return (x + 64'sd16384) >>> 15;
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (x < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return x;
	endfunction

	// Update the shadow grid and taps for one command beat; queue its result if it has one.
	task automatic apply_command();
		cube_result_t r;
		longint       acc [8];
		longint       addr, w, gx, gy, gz, cre, cim, wx, wy, wz;
		int           t;
		bit           err;
		err = 0;
		for (int k = 0; k < 8; k++) acc[k] = 0;
		if (func == FN_LOAD) begin
			if (axis < 3 && tap < MAX_TAPS) begin
				win[axis][tap]  = longint'(weight);
				dwin[axis][tap] = longint'(dweight);
			end
			return;
		end
		if (func > FN_GATHER) return;
		if (func == FN_WRITE) begin
			if (grid_index < GRID_CELLS) begin
				cell_re[grid_index] = value_re;
				cell_im[grid_index] = value_im;
			end else begin
				err = 1;
			end
		end else if (func == FN_READ) begin
			if (grid_index < GRID_CELLS) begin
				acc[0] = cell_re[grid_index];
				acc[1] = cell_im[grid_index];
			end else begin
				err = 1;
			end
		end else begin
			t = taps_cfg;
			if (t > MAX_TAPS) t = MAX_TAPS;
			if (t > TAP_SPAN) t = TAP_SPAN;
			for (int a = 0; a < t; a++) begin
				for (int b = 0; b < t; b++) begin
					for (int c = 0; c < t; c++) begin
						addr = longint'(grid_index) + a * row_len * plane_cnt + b * row_len + c;
						wx = win[0][a];
						wy = win[1][b];
						wz = win[2][c];
						w  = tensor(wx, wy, wz);
						if (addr >= GRID_CELLS) begin
							err = 1;
						end else if (func == FN_SPREAD) begin
							cell_re[addr] = int'(sat32(longint'(cell_re[addr]) +
								rnd15(longint'(value_re) * w)));
							cell_im[addr] = int'(sat32(longint'(cell_im[addr]) +
								rnd15(longint'(value_im) * w)));
						end else begin
							cre = cell_re[addr];
							cim = cell_im[addr];
							gx  = tensor(dwin[0][a], wy, wz);
							gy  = tensor(wx, dwin[1][b], wz);
							gz  = tensor(wx, wy, dwin[2][c]);
							acc[0] += w * cre;  acc[1] += w * cim;
							acc[2] += gx * cre; acc[3] += gx * cim;
							acc[4] += gy * cre; acc[5] += gy * cim;
							acc[6] += gz * cre; acc[7] += gz * cim;
						end
					end
				end
			end
			// Gather sums are rounded once, after the whole cube.
			if (func == FN_GATHER) begin
				for (int k = 0; k < 8; k++) acc[k] = rnd15(acc[k]);
			end
		end
		for (int k = 0; k < 8; k++) r.sums[k] = acc[k][OUT_W-1:0];
		r.err = err;
		due_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cube_result_t act, exp_r;
		if (!arst_n) begin
			row_len     = 16;
			plane_cnt   = 16;
			taps_cfg    = 8;
			mismatches  = 0;
			outstanding = 0;
			due_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				act.sums = {gz_im, gz_re, gy_im, gy_re, gx_im, gx_re, f_im, f_re};
				act.err  = range_error;
				if (due_results.size() == 0) begin
					$display("%t: result beat with nothing expected", $realtime);
					mismatches++;
				end else begin
					exp_r = due_results.pop_front();
					for (int k = 0; k < 8; k++) begin
						if (act.sums[k] !== exp_r.sums[k]) begin
							$display("%t: %s expected %h actual %h", $realtime, sum_name[k],
								exp_r.sums[k], act.sums[k]);
							mismatches++;
						end
					end
					if (act.err !== exp_r.err) begin
						$display("%t: range_error expected %b actual %b", $realtime,
							exp_r.err, act.err);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) apply_command();
			if (cfg_we) begin
				if (cfg_index == REG_ROW_LENGTH) row_len = cfg_wdata;
				else if (cfg_index == REG_PLANE_ROWS) plane_cnt = cfg_wdata;
				else if (cfg_index == REG_TAPS_USED) taps_cfg = cfg_wdata[3:0];
			end
			outstanding = due_results.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the separable window grid unit bench: clock, reset, command stimulus and verdict.
// Depends on swg_pkg, the unit itself and swg_checker.
module tb_top;
	import swg_pkg::*;

	localparam int     GRID_CELLS = 65536;
	localparam int     N_PHASES   = 9;
	localparam int     PER_PHASE  = 95;
	// Longest beat is a full 8x8x8 cube; settle somewhat longer than one takes.
	localparam int     SETTLE     = 600;
	// Far above a run where every beat meets the longest gaps and stalls.
	localparam longint LIMIT      = 20000000;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [CFG_W-1:0]        cfg_wdata;
	logic                    in_valid;
	logic                    in_stall;
	logic [2:0]              func;
	logic [1:0]              axis;
	logic [2:0]              tap;
	logic signed [15:0]      weight;
	logic signed [15:0]      dweight;
	logic [15:0]             grid_index;
	logic signed [31:0]      value_re;
	logic signed [31:0]      value_im;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [OUT_W-1:0] f_re, f_im, gx_re, gx_im, gy_re, gy_im, gz_re, gz_im;
	logic                    range_error;
	int                      mismatches;
	int                      outstanding;

	// Cells the bench has written so far; no beat may read a cell before it is set.
	bit     written [GRID_CELLS];
	longint cur_row, cur_plane;
	int     cur_taps;
	bit     no_gaps;
	longint cycles;

	separable_window_grid_spread_gather_unit DUT (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata,
		.in_valid, .in_stall, .func, .axis, .tap, .weight, .dweight, .grid_index,
		.value_re, .value_im, .out_valid, .out_stall,
		.f_re, .f_im, .gx_re, .gx_im, .gy_re, .gy_im, .gz_re, .gz_im, .range_error
	);

	swg_checker u_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata,
		.in_valid, .in_stall, .func, .axis, .tap, .weight, .dweight, .grid_index,
		.value_re, .value_im, .out_valid, .out_stall,
		.f_re, .f_im, .gx_re, .gx_im, .gy_re, .gy_im, .gz_re, .gz_im, .range_error,
		.mismatches, .outstanding
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Result side: stall in random bursts.
	initial begin
		int stall_left;
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!no_gaps && $urandom_range(0, 99) < 25) stall_left = pick_gap();
			end
		end
	end

	// Drive one command beat and hold it until it is taken.
	task automatic send_beat(input logic [2:0] f, input logic [1:0] ax, input logic [2:0] tp,
		input logic [15:0] w, input logic [15:0] dw, input logic [15:0] gi,
		input logic [31:0] vr, input logic [31:0] vi);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		axis       <= ax;
		tap        <= tp;
		weight     <= w;
		dweight    <= dw;
		grid_index <= gi;
		value_re   <= vr;
		value_im   <= vi;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [31:0] cell_value();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $urandom_range(0, 2 ** 21) - 2 ** 20;
	endfunction

	task automatic write_cell(input logic [15:0] gi, input logic [31:0] vr,
		input logic [31:0] vi);
		send_beat(FN_WRITE, $urandom, $urandom, $urandom, $urandom, gi, vr, vi);
		written[gi] = 1;
	endtask

	// Fill any in-store cube cell not yet written, so spread and gather only see set cells.
	task automatic cover_cube(input logic [15:0] gi);
		int     t;
		longint addr;
		t = (cur_taps > TAP_SPAN) ? TAP_SPAN : cur_taps;
		for (int a = 0; a < t; a++) begin
			for (int b = 0; b < t; b++) begin
				for (int c = 0; c < t; c++) begin
					addr = longint'(gi) + a * cur_row * cur_plane + b * cur_row + c;
					if (addr < GRID_CELLS && !written[addr])
						write_cell(addr[15:0], cell_value(), cell_value());
				end
			end
		end
	endtask

	task automatic cube_beat(input logic [2:0] f, input logic [15:0] gi,
		input logic [31:0] vr, input logic [31:0] vi);
		cover_cube(gi);
		send_beat(f, $urandom, $urandom, $urandom, $urandom, gi, vr, vi);
	endtask

	function automatic logic [15:0] pick_base();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(0, 767);
		if (r < 87) return $urandom_range(65024, 65535);
		if (r < 96) return $urandom_range(30000, 30300);
		return $urandom;
	endfunction

	task automatic random_beat();
		int          r;
		logic [15:0] gi;
		r  = $urandom_range(0, 99);
		gi = pick_base();
		if (r < 8) begin
			send_beat(FN_LOAD, $urandom_range(0, 3), $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
		end else if (r < 20) begin
			write_cell(gi, cell_value(), cell_value());
		end else if (r < 32) begin
			if (!written[gi]) write_cell(gi, cell_value(), cell_value());
			send_beat(FN_READ, $urandom, $urandom, $urandom, $urandom, gi, $urandom, $urandom);
		end else if (r < 64) begin
			cube_beat(FN_SPREAD, gi, cell_value(), cell_value());
		end else if (r < 96) begin
			cube_beat(FN_GATHER, gi, $urandom, $urandom);
		end else begin
			send_beat($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
		end
	endtask

	// Drain the unit, then write all three registers.
	task automatic set_config(input longint rl, input longint pr, input int tu);
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROW_LENGTH;
		cfg_wdata <= rl;
		@(posedge clk);
		cfg_index <= REG_PLANE_ROWS;
		cfg_wdata <= pr;
		@(posedge clk);
		cfg_index <= REG_TAPS_USED;
		cfg_wdata <= tu;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_row   = rl;
		cur_plane = pr;
		cur_taps  = tu;
	endtask

	initial begin
		longint ph_row   [N_PHASES] = '{16, 1, 4, 65536, 0, 131071, 8, 0, 16};
		longint ph_plane [N_PHASES] = '{16, 1, 4, 65536, 0, 1, 3, 0, 16};
		int     ph_taps  [N_PHASES] = '{8, 1, 3, 2, 0, 15, 4, 0, 8};
		cycles     = 0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_ROW_LENGTH;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		func       = FN_LOAD;
		axis       = AXIS_X;
		tap        = '0;
		weight     = '0;
		dweight    = '0;
		grid_index = '0;
		value_re   = '0;
		value_im   = '0;
		no_gaps    = 0;
		cur_row    = 16;
		cur_plane  = 16;
		cur_taps   = 8;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every tap, with the Q1.15 extremes on the first two of each axis.
		for (int ax = 0; ax < 3; ax++) begin
			for (int tp = 0; tp < 8; tp++) begin
				send_beat(FN_LOAD, ax, tp,
					(tp == 0) ? 16'h7fff : (tp == 1) ? 16'h8000 : 16'($urandom),
					(tp == 0) ? 16'h8000 : (tp == 1) ? 16'h7fff : 16'($urandom),
					$urandom, $urandom, $urandom);
			end
		end
		// Bad axis is ignored; unknown commands return nothing.
		send_beat(FN_LOAD, 2'd3, 3'd0, 16'h1234, 16'h4321, 0, 0, 0);
		send_beat(3'd5, 0, 0, 0, 0, 0, 0, 0);
		send_beat(3'd7, 0, 0, 0, 0, 16'hffff, 32'hffffffff, 32'hffffffff);
		write_cell(16'd0, 32'h7fffffff, 32'h80000000);
		write_cell(16'hffff, 32'h80000000, 32'h7fffffff);
		send_beat(FN_READ, 0, 0, 0, 0, 16'hffff, 0, 0);
		send_beat(FN_READ, 0, 0, 0, 0, 16'd0, 0, 0);
		// Full-scale spread drives cells into saturation.
		cube_beat(FN_SPREAD, 16'd0, 32'h7fffffff, 32'h80000000);
		cube_beat(FN_GATHER, 16'd0, 0, 0);
		// Cube running off the end of the store.
		cube_beat(FN_SPREAD, 16'hffff, 32'h80000000, 32'h7fffffff);
		cube_beat(FN_GATHER, 16'hff80, 0, 0);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 7) set_config($urandom_range(1, 64), $urandom_range(1, 16),
				$urandom_range(1, 8));
			else set_config(ph_row[p], ph_plane[p], ph_taps[p]);
			no_gaps = (p == 2 || p == 6);
			for (int i = 0; i < PER_PHASE; i++) random_beat();
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> sim.f
design/swg_pkg.sv
design/swg_ram.sv
design/swg_front.sv
design/swg_queue.sv
design/swg_back.sv
design/separable_window_grid_spread_gather_unit.sv
verif/swg_checker.sv
verif/tb_top.sv
